// ===== src/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Types, codes and sizes shared by the ARP cache and responder modules.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Depth of the command queue between front and back; a power of two.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int KIND_W  = 8;
    localparam int PORT_W  = 2;
    localparam int PROTO_W = 16;
    localparam int OPC_W   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP = CFG_IDX_W'(0);

    localparam logic [PROTO_W-1:0] PROTO_IPV4    = 16'h0800;
    localparam logic [OPC_W-1:0]   OPC_REQUEST   = 16'd1;
    localparam logic [KIND_W-1:0]  KIND_ETHERNET = 8'd1;

    typedef enum logic [1:0] {
        ACT_RX     = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_ADD    = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_IGNORED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_IGNORE,
        CMD_REQUEST,
        CMD_CACHE,
        CMD_LOOKUP,
        CMD_ADD,
        CMD_REMOVE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [KIND_W-1:0]  kind;
        logic [PORT_W-1:0]  port;
        logic               reply_valid;
        logic [MAC_W-1:0]   reply_mac;
        logic [IP_W-1:0]    reply_ip;
    } cmd_t;

    typedef struct packed {
        logic               valid;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [KIND_W-1:0]  kind;
        logic [PORT_W-1:0]  port;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// arpc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/arpc_front.sv =====
// ----------------------------------------------------------------------------
// arpc_front
// Accepts items, holds the own address register and classifies each item
// into a table command, working out the reply fields up front.
// ----------------------------------------------------------------------------
module arpc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    action,
    input  logic [arpc_pkg::PROTO_W-1:0]  proto_type,
    input  logic [arpc_pkg::OPC_W-1:0]    opcode,
    input  logic [arpc_pkg::MAC_W-1:0]    hw_addr,
    input  logic [arpc_pkg::IP_W-1:0]     ip_addr,
    input  logic [arpc_pkg::IP_W-1:0]     target_ip,
    input  logic [arpc_pkg::KIND_W-1:0]   hw_kind,
    input  logic [arpc_pkg::PORT_W-1:0]   port,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          clearing,
    input  logic                          q_full,
    output logic                          q_push,
    output arpc_pkg::cmd_t                q_cmd
);
    import arpc_pkg::*;

    logic [IP_W-1:0] own_ip_reg;
    logic            is_ipv4;
    logic            is_request;

    // A write to the own hardware address is accepted, but no result field
    // carries it, so only the own IP address is kept.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else if (cfg_valid && cfg_ready && cfg_index == CFG_OWN_IP)
        begin
            own_ip_reg <= cfg_data[IP_W-1:0];
        end
    end

    assign full   = q_full || clearing;
    assign q_push = push && !full;

    assign is_ipv4    = (proto_type == PROTO_IPV4);
    assign is_request = (opcode == OPC_REQUEST);

    always_comb
    begin
        q_cmd             = '0;
        q_cmd.ip          = ip_addr;
        q_cmd.mac         = hw_addr;
        q_cmd.port        = port;
        q_cmd.kind        = hw_kind;
        q_cmd.op          = CMD_IGNORE;
        unique case (action_t'(action))
            ACT_RX:
            begin
                q_cmd.kind = KIND_ETHERNET;
                if (!is_ipv4)
                begin
                    q_cmd.op = CMD_IGNORE;
                end
                else if (is_request)
                begin
                    q_cmd.op = CMD_REQUEST;
                    if (own_ip_reg != '0 && target_ip == own_ip_reg)
                    begin
                        q_cmd.reply_valid = 1'b1;
                        q_cmd.reply_mac   = hw_addr;
                        q_cmd.reply_ip    = ip_addr;
                    end
                end
                else
                begin
                    q_cmd.op = CMD_CACHE;
                end
            end
            ACT_LOOKUP: q_cmd.op = CMD_LOOKUP;
            ACT_ADD:    q_cmd.op = CMD_ADD;
            ACT_REMOVE: q_cmd.op = CMD_REMOVE;
        endcase
    end

endmodule

// ===== src/arpc_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// arpc_cmd_fifo
// Short command queue that decouples the front from the table walker.
// ----------------------------------------------------------------------------
module arpc_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  arpc_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output arpc_pkg::cmd_t cmd_out,
    output logic           empty
);
    import arpc_pkg::*;

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                slot_reg[wr_ptr_reg] <= cmd_in;
                wr_ptr_reg           <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/arpc_back.sv =====
// ----------------------------------------------------------------------------
// arpc_back
// Table walker: clears the table after reset, scans it once per non-ignored
// command to find the matching and the lowest free entry, updates it and queues the
// result item.
// ----------------------------------------------------------------------------
module arpc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  arpc_pkg::cmd_t                q_cmd,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    status,
    output logic                          reply_valid,
    output logic [arpc_pkg::MAC_W-1:0]    reply_dest_mac,
    output logic [arpc_pkg::IP_W-1:0]     reply_dest_ip,
    output logic [arpc_pkg::MAC_W-1:0]    found_mac,
    output logic [arpc_pkg::KIND_W-1:0]   found_kind,
    output logic [arpc_pkg::PORT_W-1:0]   found_port
);
    import arpc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RESULT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    cmd_t               cmd_reg;
    logic               chk_valid_reg;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic               match_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [MAC_W-1:0]   match_mac_reg;
    logic [KIND_W-1:0]  match_kind_reg;
    logic [PORT_W-1:0]  match_port_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    status_t            pend_status_reg;
    logic [MAC_W-1:0]   pend_mac_reg;
    logic [KIND_W-1:0]  pend_kind_reg;
    logic [PORT_W-1:0]  pend_port_reg;

    logic               res_valid_reg;
    status_t            status_reg;
    logic               reply_valid_reg;
    logic [MAC_W-1:0]   reply_mac_reg;
    logic [IP_W-1:0]    reply_ip_reg;
    logic [MAC_W-1:0]   found_mac_reg;
    logic [KIND_W-1:0]  found_kind_reg;
    logic [PORT_W-1:0]  found_port_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wentry;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    logic               do_insert;
    logic               slot_ok;
    logic [IDX_W-1:0]   ins_idx;
    status_t            dec_status;
    logic               dec_found;
    logic               scan_last;

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign ram_re    = (state_reg == S_SCAN) && (cnt_reg < CNT_W'(TABLE_ENTRIES));
    assign scan_last = (cnt_reg == CNT_W'(TABLE_ENTRIES));
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign clearing  = (state_reg == S_CLEAR);

    // A request only refreshes the table when the sender is new or moved.
    always_comb
    begin
        do_insert  = 1'b0;
        dec_status = STATUS_OK;
        dec_found  = 1'b0;
        slot_ok    = match_reg || free_reg;
        ins_idx    = match_reg ? match_idx_reg : free_idx_reg;
        unique case (cmd_reg.op)
            CMD_REQUEST: do_insert = !match_reg || (match_mac_reg != cmd_reg.mac);
            CMD_CACHE:   do_insert = 1'b1;
            CMD_ADD:     do_insert = 1'b1;
            CMD_LOOKUP:
            begin
                dec_status = match_reg ? STATUS_OK : STATUS_NOT_FOUND;
                dec_found  = match_reg;
            end
            CMD_REMOVE:  dec_status = match_reg ? STATUS_OK : STATUS_NOT_FOUND;
            default:     dec_status = STATUS_IGNORED;
        endcase
        if (do_insert && !slot_ok)
        begin
            dec_status = STATUS_FULL;
        end
    end

    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg[IDX_W-1:0];
        ram_wentry = '0;
        if (state_reg == S_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_DECIDE)
        begin
            if (do_insert && slot_ok)
            begin
                ram_we           = 1'b1;
                ram_waddr        = ins_idx;
                ram_wentry.valid = 1'b1;
                ram_wentry.ip    = cmd_reg.ip;
                ram_wentry.mac   = cmd_reg.mac;
                ram_wentry.kind  = cmd_reg.kind;
                ram_wentry.port  = cmd_reg.port;
            end
            else if (cmd_reg.op == CMD_REMOVE && match_reg)
            begin
                ram_we    = 1'b1;
                ram_waddr = match_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            cmd_reg         <= '0;
            chk_valid_reg   <= 1'b0;
            chk_idx_reg     <= '0;
            match_reg       <= 1'b0;
            match_idx_reg   <= '0;
            match_mac_reg   <= '0;
            match_kind_reg  <= '0;
            match_port_reg  <= '0;
            free_reg        <= 1'b0;
            free_idx_reg    <= '0;
            pend_status_reg <= STATUS_OK;
            pend_mac_reg    <= '0;
            pend_kind_reg   <= '0;
            pend_port_reg   <= '0;
            res_valid_reg   <= 1'b0;
            status_reg      <= STATUS_OK;
            reply_valid_reg <= 1'b0;
            reply_mac_reg   <= '0;
            reply_ip_reg    <= '0;
            found_mac_reg   <= '0;
            found_kind_reg  <= '0;
            found_port_reg  <= '0;
        end
        else
        begin
            // In the result state the output register is refilled below.
            if (pop && res_valid_reg && state_reg != S_RESULT)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg       <= q_cmd;
                        cnt_reg       <= '0;
                        chk_valid_reg <= 1'b0;
                        match_reg     <= 1'b0;
                        free_reg      <= 1'b0;
                        if (q_cmd.op == CMD_IGNORE)
                        begin
                            pend_status_reg <= STATUS_IGNORED;
                            pend_mac_reg    <= '0;
                            pend_kind_reg   <= '0;
                            pend_port_reg   <= '0;
                            state_reg       <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // Read data is registered and arrives in the cycle after its address.
                    chk_valid_reg <= ram_re;
                    chk_idx_reg   <= cnt_reg[IDX_W-1:0];
                    if (ram_re)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (chk_valid_reg)
                    begin
                        if (rd_entry.valid && rd_entry.ip == cmd_reg.ip && !match_reg)
                        begin
                            match_reg      <= 1'b1;
                            match_idx_reg  <= chk_idx_reg;
                            match_mac_reg  <= rd_entry.mac;
                            match_kind_reg <= rd_entry.kind;
                            match_port_reg <= rd_entry.port;
                        end
                        if (!rd_entry.valid && !free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= chk_idx_reg;
                        end
                    end
                    if (scan_last)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    pend_status_reg <= dec_status;
                    pend_mac_reg    <= dec_found ? match_mac_reg : '0;
                    pend_kind_reg   <= dec_found ? match_kind_reg : '0;
                    pend_port_reg   <= dec_found ? match_port_reg : '0;
                    state_reg       <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (!res_valid_reg || pop)
                    begin
                        res_valid_reg   <= 1'b1;
                        status_reg      <= pend_status_reg;
                        reply_valid_reg <= cmd_reg.reply_valid;
                        reply_mac_reg   <= cmd_reg.reply_mac;
                        reply_ip_reg    <= cmd_reg.reply_ip;
                        found_mac_reg   <= pend_mac_reg;
                        found_kind_reg  <= pend_kind_reg;
                        found_port_reg  <= pend_port_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign empty          = !res_valid_reg;
    assign status         = status_reg;
    assign reply_valid    = reply_valid_reg;
    assign reply_dest_mac = reply_mac_reg;
    assign reply_dest_ip  = reply_ip_reg;
    assign found_mac      = found_mac_reg;
    assign found_kind     = found_kind_reg;
    assign found_port     = found_port_reg;

endmodule

// ===== src/arp_cache_responder.sv =====
// ----------------------------------------------------------------------------
// arp_cache_responder
// ARP cache with request responder, queue-style item and result channels.
// ----------------------------------------------------------------------------
// Each item is paced by the walk over the table RAM, one entry per cycle
// through its single read port; a packet of a foreign protocol skips the
// walk. The front keeps accepting items into a two-deep command queue while
// the walk runs, and a finished result waits in an output register without
// holding up the next walk. After reset a clearing pass over all
// TABLE_ENTRIES entries invalidates the table, and full stays high until it
// ends; configuration writes are taken at any time.
module arp_cache_responder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      action,
    input  logic [arpc_pkg::PROTO_W-1:0]    proto_type,
    input  logic [arpc_pkg::OPC_W-1:0]      opcode,
    input  logic [arpc_pkg::MAC_W-1:0]      hw_addr,
    input  logic [arpc_pkg::IP_W-1:0]       ip_addr,
    input  logic [arpc_pkg::IP_W-1:0]       target_ip,
    input  logic [arpc_pkg::KIND_W-1:0]     hw_kind,
    input  logic [arpc_pkg::PORT_W-1:0]     port,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      status,
    output logic                            reply_valid,
    output logic [arpc_pkg::MAC_W-1:0]      reply_dest_mac,
    output logic [arpc_pkg::IP_W-1:0]       reply_dest_ip,
    output logic [arpc_pkg::MAC_W-1:0]      found_mac,
    output logic [arpc_pkg::KIND_W-1:0]     found_kind,
    output logic [arpc_pkg::PORT_W-1:0]     found_port,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arpc_pkg::*;

    logic clearing;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    cmd_t q_cmd_in;
    cmd_t q_cmd_out;

    arpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .proto_type (proto_type),
        .opcode     (opcode),
        .hw_addr    (hw_addr),
        .ip_addr    (ip_addr),
        .target_ip  (target_ip),
        .hw_kind    (hw_kind),
        .port       (port),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .clearing   (clearing),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd_in)
    );

    arpc_cmd_fifo u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (q_cmd_in),
        .full    (q_full),
        .pop     (q_pop),
        .cmd_out (q_cmd_out),
        .empty   (q_empty)
    );

    arpc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_cmd          (q_cmd_out),
        .q_pop          (q_pop),
        .clearing       (clearing),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .reply_valid    (reply_valid),
        .reply_dest_mac (reply_dest_mac),
        .reply_dest_ip  (reply_dest_ip),
        .found_mac      (found_mac),
        .found_kind     (found_kind),
        .found_port     (found_port)
    );

    // No item may enter while the table is still being cleared.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("item channel open during table clearing");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue written while full");

    // A reply only comes with a request, which never misses or is ignored.
    a_reply_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reply_valid) |->
            (status != STATUS_NOT_FOUND && status != STATUS_IGNORED))
        else $error("reply with inconsistent status");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != STATUS_OK) |->
            (found_mac == '0 && found_kind == '0 && found_port == '0))
        else $error("found fields set on a failed item");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(found_mac)))
        else $error("waiting result changed before it was taken");

endmodule
